// ----- rtl/nvdl_pkg.sv -----
// ============================================================================
// nvdl_pkg
// Types, constants and fixed-point helpers for the negative vapor limiter.
// ============================================================================
package nvdl_pkg;

    localparam int W = 48;
    localparam int CVW = 32;
    localparam int NUM_VAPOR_DEF = 3;
    localparam int NUM_CFG = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_CV_DRY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CV_A   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CV_B   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CV_C   = 2'd3;

    localparam logic [CVW-1:0] CV_DRY_RST = 32'd46989312;
    localparam logic [CVW-1:0] CV_VAP_RST = 32'd92405760;

    typedef struct packed {
        logic signed [W-1:0] dry_density;
        logic signed [W-1:0] vapor_density_a;
        logic signed [W-1:0] vapor_density_b;
        logic signed [W-1:0] vapor_density_c;
        logic signed [W-1:0] momentum_x;
        logic signed [W-1:0] momentum_y;
        logic signed [W-1:0] momentum_z;
        logic signed [W-1:0] total_energy;
        logic                bottom_cell;
    } t_in;

    typedef struct packed {
        logic signed [W-1:0] out_dry_density;
        logic signed [W-1:0] out_vapor_a;
        logic signed [W-1:0] out_vapor_b;
        logic signed [W-1:0] out_vapor_c;
        logic signed [W-1:0] out_momentum_x;
        logic signed [W-1:0] out_momentum_y;
        logic signed [W-1:0] out_momentum_z;
        logic signed [W-1:0] out_energy;
        logic                column_end;
    } t_out;

    typedef struct packed {
        logic                start;
        logic signed [W-1:0] num;
        logic signed [W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic signed [W-1:0] quo;
    } t_div_rsp;

    function automatic logic signed [W-1:0] sat49(input logic signed [W:0] x);
        if (x > $signed({1'b0, MAXV})) begin
            return MAXV;
        end else if (x < $signed({1'b1, MINV})) begin
            return MINV;
        end
        return x[W-1:0];
    endfunction

    // Saturation of a sum of up to four values, held with two guard bits.
    function automatic logic signed [W-1:0] sat_wide(input logic signed [W+1:0] x);
        if (x > $signed({2'b00, MAXV})) begin
            return MAXV;
        end else if (x < $signed({2'b11, MINV})) begin
            return MINV;
        end
        return x[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        return sat49(s);
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        return sat49(s);
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        return x[W-1] ? W'(-x) : W'(x);
    endfunction

    // Signed saturation of a magnitude of up to W+1 bits.
    function automatic logic signed [W-1:0] sgn_sat(input logic [W:0] m, input logic neg);
        if (neg) begin
            if (m >= (W+1)'(1) << (W-1)) begin
                return MINV;
            end
            return W'(-$signed({1'b0, m}));
        end
        if (m > {2'b00, {(W-1){1'b1}}}) begin
            return MAXV;
        end
        return m[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] half(input logic signed [W-1:0] x);
        logic signed [W-1:0] t;
        t = x + W'(x[W-1]);
        return t >>> 1;
    endfunction

endpackage

// ----- rtl/nvdl_mul.sv -----
// ============================================================================
// nvdl_mul
// Shared multiplier: Q24.24 by Q24.24 or Q24.24 by Q16.16, one 24x24, 32x32 or
// 32x16 partial product per cycle, then saturation.
// ============================================================================
module nvdl_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_cv_mode,
    input  logic signed [nvdl_pkg::W-1:0]  i_a,
    input  logic signed [nvdl_pkg::W-1:0]  i_b,
    input  logic [nvdl_pkg::CVW-1:0]       i_cv,
    output logic                           o_done,
    output logic signed [nvdl_pkg::W-1:0]  o_p
);
    localparam int W = nvdl_pkg::W;
    localparam int H = W / 2;

    logic [2:0]      r_step, n_step;
    logic            r_busy, n_busy;
    logic            r_cv, r_neg;
    logic [W-1:0]    r_ua, r_ub;
    logic [31:0]     r_cvv;
    logic [63:0]     r_acc;
    logic [63:0]     r_hh;
    logic [31:0]     r_fa;
    logic [31:0]     r_fb;
    logic [63:0]     w_pp;

    assign w_pp = {32'd0, r_fa} * {32'd0, r_fb};

    always_comb begin
        r_fa = '0;
        r_fb = '0;
        if (r_cv) begin
            r_fa = r_cvv;
            r_fb = (r_step == 3'd0) ? 32'(r_ua[W-1:16]) : 32'(r_ua[15:0]);
        end else begin
            unique case (r_step)
                3'd0: begin r_fa = 32'(r_ua[W-1:H]); r_fb = 32'(r_ub[W-1:H]); end
                3'd1: begin r_fa = 32'(r_ua[W-1:H]); r_fb = 32'(r_ub[H-1:0]); end
                3'd2: begin r_fa = 32'(r_ua[H-1:0]); r_fb = 32'(r_ub[W-1:H]); end
                default: begin r_fa = 32'(r_ua[H-1:0]); r_fb = 32'(r_ub[H-1:0]); end
            endcase
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (r_busy) begin
            n_step = r_step + 3'd1;
            if ((r_cv && r_step == 3'd1) || r_step == 3'd3) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            o_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            o_done <= r_busy && !n_busy && !i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cv  <= i_cv_mode;
            r_ua  <= nvdl_pkg::mag(i_a);
            r_ub  <= nvdl_pkg::mag(i_b);
            r_cvv <= i_cv;
            r_neg <= i_cv_mode ? i_a[W-1] : (i_a[W-1] ^ i_b[W-1]);
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cv) begin
                if (r_step == 3'd0) begin
                    r_hh  <= w_pp;
                    r_acc <= w_pp;
                end else begin
                    r_acc <= r_acc + (w_pp >> 16);
                end
            end else begin
                unique case (r_step)
                    3'd0: begin r_hh <= w_pp; r_acc <= w_pp << H; end
                    3'd1: r_acc <= r_acc + w_pp;
                    3'd2: r_acc <= r_acc + w_pp;
                    default: r_acc <= r_acc + (w_pp >> H);
                endcase
            end
        end
    end

    logic big;
    always_comb begin
        if (r_cv) begin
            big = r_hh >= (64'd1 << W);
        end else begin
            big = r_hh >= (64'd1 << (H - 1));
        end
        if (big || r_acc >= (64'd1 << W)) begin
            o_p = nvdl_pkg::sgn_sat({1'b1, {W{1'b0}}}, r_neg);
        end else begin
            o_p = nvdl_pkg::sgn_sat(r_acc[W:0], r_neg);
        end
    end
endmodule

// ----- rtl/nvdl_div.sv -----
// ============================================================================
// nvdl_div
// Shared restoring divider for signed Q24.24, one quotient bit per cycle.
// ============================================================================
module nvdl_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nvdl_pkg::t_div_req    i_req,
    output nvdl_pkg::t_div_rsp    o_rsp
);
    localparam int W = nvdl_pkg::W;
    localparam int F = W / 2;
    localparam int NB = W + F;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0]  r_num;
    logic [W:0]     r_rem;
    logic [W-1:0]   r_den;
    logic [NB-1:0]  r_q;
    logic [CW-1:0]  r_cnt;
    logic           r_busy, r_done, r_neg, r_zero, r_aneg;
    logic [W:0]     w_sh;
    logic [W:0]     w_sub;

    assign w_sh  = {r_rem[W-1:0], r_num[NB-1]};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= {nvdl_pkg::mag(i_req.num), {F{1'b0}}};
            r_den  <= nvdl_pkg::mag(i_req.den);
            r_rem  <= '0;
            r_q    <= '0;
            r_neg  <= i_req.num[W-1] ^ i_req.den[W-1];
            r_aneg <= i_req.num[W-1];
            r_zero <= (i_req.den == '0);
        end else if (r_busy) begin
            r_num <= r_num << 1;
            if (!w_sub[W]) begin
                r_rem <= w_sub;
                r_q   <= {r_q[NB-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[NB-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        o_rsp.busy = r_busy;
        o_rsp.done = r_done;
        if (r_zero) begin
            o_rsp.quo = r_aneg ? nvdl_pkg::MINV : nvdl_pkg::MAXV;
        end else if (r_q[NB-1:W-1] != '0) begin
            o_rsp.quo = nvdl_pkg::sgn_sat({1'b1, {W{1'b0}}}, r_neg);
        end else begin
            o_rsp.quo = nvdl_pkg::sgn_sat({1'b0, r_q[W-1:0]}, r_neg);
        end
    end
endmodule

// ----- rtl/negative_vapor_downward_limiter.sv -----
// ============================================================================
// negative_vapor_downward_limiter
// Moves negative vapor, with its momentum and energy, down a column of cells.
// ============================================================================
// channel | direction | handshake              | payload
// in      | input     | i_valid / o_stall      | i_data  (t_in)
// out     | output    | o_valid / i_stall      | o_data  (t_out)
// cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// A bottom cell goes straight to the output; an ordinary cell runs four divisions
// and NUM_VAPOR+5 multiplications, plus five more for each negative vapor,
// on the single shared divider and multiplier.
// Reset is synchronous, clears the carry and loads the heat capacities with their reset values.
// Input stall is high from acceptance until the result has been taken.
module negative_vapor_downward_limiter #(
    parameter int NUM_VAPOR = nvdl_pkg::NUM_VAPOR_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  nvdl_pkg::t_in                     i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output nvdl_pkg::t_out                    o_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nvdl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nvdl_pkg::CVW-1:0]          i_cfg_data
);
    localparam int W = nvdl_pkg::W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RCV  = 4'd1;
    localparam logic [3:0] S_DIVV = 4'd2;
    localparam logic [3:0] S_VSQ  = 4'd3;
    localparam logic [3:0] S_KE   = 4'd4;
    localparam logic [3:0] S_TMP  = 4'd5;
    localparam logic [3:0] S_ENM  = 4'd6;
    localparam logic [3:0] S_ENE  = 4'd7;
    localparam logic [3:0] S_MOM  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]                 r_state;
    logic [1:0]                 r_k;
    logic [1:0]                 r_vi;
    logic                       r_wait;
    logic [nvdl_pkg::CVW-1:0]   r_cv [nvdl_pkg::NUM_CFG];
    logic signed [W-1:0]        r_d [4];
    logic signed [W-1:0]        r_m [3];
    logic signed [W-1:0]        r_e;
    logic                       r_bot;
    logic signed [W-1:0]        r_cvap [3];
    logic signed [W-1:0]        r_cmom [3];
    logic signed [W-1:0]        r_cen;
    logic signed [W-1:0]        r_rho, r_rhocv, r_vsq, r_temp, r_en;
    logic signed [W+1:0]        r_rsum, r_csum;
    logic signed [W-1:0]        r_v [3];

    logic                       w_mstart, w_mcv, w_mdone;
    logic signed [W-1:0]        w_ma, w_mb, w_mp;
    logic [nvdl_pkg::CVW-1:0]   w_mcvv;
    nvdl_pkg::t_div_req         w_dreq;
    nvdl_pkg::t_div_rsp         w_drsp;
    logic                       w_acc;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_acc       = i_valid && !o_stall;
    assign o_valid     = (r_state == S_OUT);

    always_comb begin
        o_data.out_dry_density = r_d[0];
        o_data.out_vapor_a     = r_d[1];
        o_data.out_vapor_b     = r_d[2];
        o_data.out_vapor_c     = r_d[3];
        o_data.out_momentum_x  = r_m[0];
        o_data.out_momentum_y  = r_m[1];
        o_data.out_momentum_z  = r_m[2];
        o_data.out_energy      = r_e;
        o_data.column_end      = r_bot;
    end

    nvdl_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart), .i_cv_mode(w_mcv),
        .i_a(w_ma), .i_b(w_mb), .i_cv(w_mcvv), .o_done(w_mdone), .o_p(w_mp)
    );

    nvdl_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // Operand selection for the shared units, issued on the first cycle of a step.
    always_comb begin
        w_mstart = 1'b0;
        w_mcv    = 1'b0;
        w_ma     = '0;
        w_mb     = '0;
        w_mcvv   = r_cv[r_k];
        w_dreq.start = 1'b0;
        w_dreq.num   = r_m[r_vi];
        w_dreq.den   = r_rho;
        unique case (r_state)
            S_RCV: begin
                w_mstart = !r_wait;
                w_mcv    = 1'b1;
                w_ma     = r_d[r_k];
            end
            S_DIVV: w_dreq.start = !r_wait;
            S_VSQ: begin
                w_mstart = !r_wait;
                w_ma     = r_v[r_vi];
                w_mb     = r_v[r_vi];
            end
            S_KE: begin
                w_mstart = !r_wait;
                w_ma     = nvdl_pkg::half(r_rho);
                w_mb     = r_vsq;
            end
            S_TMP: begin
                w_dreq.start = !r_wait;
                w_dreq.num   = r_en;
                w_dreq.den   = r_rhocv;
            end
            S_ENM: begin
                w_mstart = !r_wait;
                w_mcv    = 1'b1;
                w_ma     = r_temp;
            end
            S_ENE: begin
                w_mstart = !r_wait;
                w_ma     = r_en;
                w_mb     = r_d[r_k];
            end
            S_MOM: begin
                w_mstart = !r_wait;
                w_ma     = r_v[r_vi];
                w_mb     = r_d[r_k];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[nvdl_pkg::CFG_CV_DRY] <= nvdl_pkg::CV_DRY_RST;
            r_cv[nvdl_pkg::CFG_CV_A]   <= nvdl_pkg::CV_VAP_RST;
            r_cv[nvdl_pkg::CFG_CV_B]   <= nvdl_pkg::CV_VAP_RST;
            r_cv[nvdl_pkg::CFG_CV_C]   <= nvdl_pkg::CV_VAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cv[i_cfg_index] <= i_cfg_data;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_k     <= '0;
            r_vi    <= '0;
            r_bot   <= 1'b0;
            r_cen   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_cvap[i] <= '0;
                r_cmom[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_d[0] <= i_data.dry_density;
                        r_d[1] <= (NUM_VAPOR >= 1) ?
                            nvdl_pkg::sat_add(i_data.vapor_density_a, r_cvap[0])
                            : i_data.vapor_density_a;
                        r_d[2] <= (NUM_VAPOR >= 2) ?
                            nvdl_pkg::sat_add(i_data.vapor_density_b, r_cvap[1])
                            : i_data.vapor_density_b;
                        r_d[3] <= (NUM_VAPOR >= 3) ?
                            nvdl_pkg::sat_add(i_data.vapor_density_c, r_cvap[2])
                            : i_data.vapor_density_c;
                        r_m[0] <= nvdl_pkg::sat_add(i_data.momentum_x, r_cmom[0]);
                        r_m[1] <= nvdl_pkg::sat_add(i_data.momentum_y, r_cmom[1]);
                        r_m[2] <= nvdl_pkg::sat_add(i_data.momentum_z, r_cmom[2]);
                        r_e    <= nvdl_pkg::sat_add(i_data.total_energy, r_cen);
                        r_bot  <= i_data.bottom_cell;
                        r_cen  <= '0;
                        for (int i = 0; i < 3; i++) begin
                            r_cvap[i] <= '0;
                            r_cmom[i] <= '0;
                        end
                        r_rsum  <= {{2{i_data.dry_density[W-1]}}, i_data.dry_density};
                        r_csum  <= '0;
                        r_k     <= '0;
                        r_vi    <= '0;
                        r_wait  <= 1'b0;
                        r_state <= i_data.bottom_cell ? S_OUT : S_RCV;
                    end
                end
                S_RCV: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                        if (r_k != '0) begin
                            r_rsum <= r_rsum + {{2{r_d[r_k][W-1]}}, r_d[r_k]};
                        end
                    end else if (w_mdone) begin
                        r_wait <= 1'b0;
                        r_csum <= r_csum + {{2{w_mp[W-1]}}, w_mp};
                        if (32'(r_k) == NUM_VAPOR) begin
                            r_rho   <= nvdl_pkg::sat_wide(r_rsum);
                            r_rhocv <= nvdl_pkg::sat_wide(r_csum + {{2{w_mp[W-1]}}, w_mp});
                            r_state <= S_DIVV;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                S_DIVV: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (w_drsp.done) begin
                        r_wait    <= 1'b0;
                        r_v[r_vi] <= w_drsp.quo;
                        if (r_vi == 2'd2) begin
                            r_vi    <= '0;
                            r_vsq   <= '0;
                            r_state <= S_VSQ;
                        end else begin
                            r_vi <= r_vi + 2'd1;
                        end
                    end
                end
                S_VSQ: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (w_mdone) begin
                        r_wait <= 1'b0;
                        r_vsq  <= nvdl_pkg::sat_add(r_vsq, w_mp);
                        if (r_vi == 2'd2) begin
                            r_vi    <= '0;
                            r_state <= S_KE;
                        end else begin
                            r_vi <= r_vi + 2'd1;
                        end
                    end
                end
                S_KE: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (w_mdone) begin
                        r_wait  <= 1'b0;
                        r_en    <= nvdl_pkg::sat_sub(r_e, w_mp);
                        r_state <= S_TMP;
                    end
                end
                S_TMP: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (w_drsp.done) begin
                        r_wait  <= 1'b0;
                        r_temp  <= w_drsp.quo;
                        r_k     <= 2'd1;
                        r_state <= S_ENM;
                    end
                end
                S_ENM: begin
                    if (!r_wait) begin
                        if (32'(r_k) > NUM_VAPOR) begin
                            r_state <= S_OUT;
                        end else if (!r_d[r_k][W-1]) begin
                            r_k <= r_k + 2'd1;
                            if (r_k == 2'd3) begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_wait <= 1'b1;
                        end
                    end else if (w_mdone) begin
                        r_wait  <= 1'b0;
                        r_en    <= nvdl_pkg::sat_add(w_mp, nvdl_pkg::half(r_vsq));
                        r_state <= S_ENE;
                    end
                end
                S_ENE: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (w_mdone) begin
                        r_wait  <= 1'b0;
                        r_cen   <= nvdl_pkg::sat_add(r_cen, w_mp);
                        r_e     <= nvdl_pkg::sat_sub(r_e, w_mp);
                        r_vi    <= '0;
                        r_state <= S_MOM;
                    end
                end
                S_MOM: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (w_mdone) begin
                        r_wait      <= 1'b0;
                        r_cmom[r_vi] <= nvdl_pkg::sat_add(r_cmom[r_vi], w_mp);
                        r_m[r_vi]    <= nvdl_pkg::sat_sub(r_m[r_vi], w_mp);
                        if (r_vi == 2'd2) begin
                            r_cvap[r_k - 2'd1] <= r_d[r_k];
                            r_d[r_k]           <= '0;
                            r_vi               <= '0;
                            r_state            <= (r_k == 2'd3) ? S_OUT : S_ENM;
                            r_k                <= r_k + 2'd1;
                        end else begin
                            r_vi <= r_vi + 2'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_stall)
        else $error("Accepted item did not start processing.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_bot) |-> (r_cen == '0))
        else $error("Carry not cleared for a bottom cell.");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mstart && w_dreq.start))
        else $error("Both shared units started together.");
endmodule
